// ----- src/tbs_pkg.sv -----
// Shared types and constants for the text byte statistics unit.
// Request/response payload structs, table and register codes, character codes.
// No dependencies.
package tbs_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 32;
    localparam int LETTERS             = 26;
    localparam int BYTE_VALUES         = 256;
    localparam int RESULT_WIDTH        = 32;

    // Request kinds
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Read targets
    typedef enum logic [1:0] {
        TBL_BYTE  = 2'd0,
        TBL_LOWER = 2'd1,
        TBL_UPPER = 2'd2,
        TBL_WORDS = 2'd3
    } table_sel_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_WORD_EN   = 2'd0;
    localparam logic [1:0] CFG_LETTER_EN = 2'd1;
    localparam logic [1:0] CFG_FOLD_CASE = 2'd2;
    localparam logic [1:0] CFG_HIST_EN   = 2'd3;

    // Character codes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
        logic [1:0] table_select;
        logic [7:0] entry_index;
    } req_t;

    typedef struct packed {
        logic [RESULT_WIDTH-1:0] count_value;
        logic                    index_error;
    } rsp_t;

endpackage

// ----- src/text_byte_statistics_unit.sv -----
// Text byte statistics unit: word count, per-letter counts and byte histogram.
// Read path: a read request's response is registered in stage 1, then in the response buffer.
// Throughput: one data byte or read per cycle, unless clearing or the rsp buffer is full.
// Counters sit in two memories with registered reads; each memory's RMW has a forwarding reg.
// Reset: asynchronous, active low; a clearing pass over all 256 addresses then zeroes every
// counter entry with req_ready held low. Config resets to histogram-only counting.
module text_byte_statistics_unit #(
    parameter int COUNT_WIDTH = tbs_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    // configuration write port
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic           cfg_wdata,
    // request channel
    input  logic           req_valid,
    output logic           req_ready,
    input  tbs_pkg::req_t  req,
    // response channel
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output tbs_pkg::rsp_t  rsp
);

    localparam int HIST_AW   = $clog2(tbs_pkg::BYTE_VALUES);
    localparam int LET_IW    = $clog2(tbs_pkg::LETTERS);
    localparam int LET_AW    = LET_IW + 1;          // table bit + letter index
    localparam int LET_DEPTH = 2 ** LET_AW;
    localparam int RSP_DEPTH = 3;
    localparam int RSP_PW    = $clog2(RSP_DEPTH);
    localparam int RSP_CW    = $clog2(RSP_DEPTH + 1);

    typedef logic [COUNT_WIDTH-1:0] cnt_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        sat_inc = (v == '1) ? v : v + COUNT_WIDTH'(1);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic word_en_reg, letter_en_reg, fold_case_reg, hist_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_en_reg   <= 1'b0;
            letter_en_reg <= 1'b0;
            fold_case_reg <= 1'b0;
            hist_en_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tbs_pkg::CFG_WORD_EN:   word_en_reg   <= cfg_wdata;
                tbs_pkg::CFG_LETTER_EN: letter_en_reg <= cfg_wdata;
                tbs_pkg::CFG_FOLD_CASE: fold_case_reg <= cfg_wdata;
                tbs_pkg::CFG_HIST_EN:   hist_en_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: decode the accepted request, issue memory reads,
    // update the word counter directly.
    // ------------------------------------------------------------------
    logic req_fire;
    logic is_read;
    logic is_lower, is_upper, is_sep;
    logic [LET_IW-1:0] lower_idx, upper_idx;
    logic [HIST_AW-1:0] hist_raddr;
    logic [LET_AW-1:0]  let_raddr;
    logic hist_we_s0, let_we_s0;
    logic idx_err_s0;
    logic [7:0] lower_off, upper_off;

    assign req_fire  = req_valid && req_ready;
    assign is_read   = (req.req_type == tbs_pkg::REQ_READ);
    assign is_sep    = (req.data_byte == tbs_pkg::CH_SPACE)
                    || (req.data_byte == tbs_pkg::CH_NEWLINE);
    assign is_lower  = (req.data_byte >= tbs_pkg::CH_LOWER_A)
                    && (req.data_byte <= tbs_pkg::CH_LOWER_Z);
    assign is_upper  = (req.data_byte >= tbs_pkg::CH_UPPER_A)
                    && (req.data_byte <= tbs_pkg::CH_UPPER_Z);
    assign lower_off = req.data_byte - tbs_pkg::CH_LOWER_A;
    assign upper_off = req.data_byte - tbs_pkg::CH_UPPER_A;
    assign lower_idx = lower_off[LET_IW-1:0];
    assign upper_idx = upper_off[LET_IW-1:0];
    assign idx_err_s0 = (req.entry_index >= 8'(tbs_pkg::LETTERS));

    always_comb
    begin
        if (is_read)
        begin
            hist_raddr = req.entry_index;
            let_raddr  = {req.table_select == tbs_pkg::TBL_UPPER,
                          req.entry_index[LET_IW-1:0]};
            hist_we_s0 = 1'b0;
            let_we_s0  = 1'b0;
        end
        else
        begin
            hist_raddr = req.data_byte;
            // uppercase goes to the lower half when folding
            if (is_upper)
                let_raddr = {!fold_case_reg, upper_idx};
            else
                let_raddr = {1'b0, lower_idx};
            hist_we_s0 = hist_en_reg;
            let_we_s0  = letter_en_reg && (is_lower || is_upper);
        end
    end

    // Word counter: advance on the first non-separator after a separator or at stream start
    cnt_t words_reg;
    logic inside_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_reg       <= '0;
            inside_word_reg <= 1'b0;
        end
        else if (req_fire && !is_read && word_en_reg)
        begin
            if (is_sep)
                inside_word_reg <= 1'b0;
            else if (!inside_word_reg)
            begin
                words_reg       <= sat_inc(words_reg);
                inside_word_reg <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Counter memories and the clearing pass after reset
    // ------------------------------------------------------------------
    cnt_t hist_mem [tbs_pkg::BYTE_VALUES];
    cnt_t let_mem  [LET_DEPTH];
    cnt_t hist_rdata_reg, let_rdata_reg;
    logic               clr_active_reg;
    logic [HIST_AW-1:0] clr_addr_reg;

    // Stage 1 registers
    logic               s1_valid_reg, s1_rd_reg;
    logic               s1_hist_we_reg, s1_let_we_reg;
    logic [HIST_AW-1:0] s1_hist_addr_reg;
    logic [LET_AW-1:0]  s1_let_addr_reg;
    logic [1:0]         s1_sel_reg;
    logic               s1_err_reg;
    cnt_t               s1_words_reg;

    // Last write of each memory, forwarded to the item read at that same edge
    logic               hist_last_we_reg, let_last_we_reg;
    logic [HIST_AW-1:0] hist_last_addr_reg;
    logic [LET_AW-1:0]  let_last_addr_reg;
    cnt_t               hist_last_data_reg, let_last_data_reg;

    cnt_t hist_cur, let_cur, hist_wdata, let_wdata;
    logic hist_we, let_we;

    assign hist_cur = (hist_last_we_reg && hist_last_addr_reg == s1_hist_addr_reg)
                    ? hist_last_data_reg : hist_rdata_reg;
    assign let_cur  = (let_last_we_reg && let_last_addr_reg == s1_let_addr_reg)
                    ? let_last_data_reg : let_rdata_reg;
    assign hist_we    = s1_valid_reg && s1_hist_we_reg;
    assign let_we     = s1_valid_reg && s1_let_we_reg;
    assign hist_wdata = sat_inc(hist_cur);
    assign let_wdata  = sat_inc(let_cur);

    // Zero one address per cycle while clearing; no request is admitted meanwhile
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
            hist_mem[clr_addr_reg] <= '0;
        else if (hist_we)
            hist_mem[s1_hist_addr_reg] <= hist_wdata;
        if (req_fire)
            hist_rdata_reg <= hist_mem[hist_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
            let_mem[clr_addr_reg[LET_AW-1:0]] <= '0;
        else if (let_we)
            let_mem[s1_let_addr_reg] <= let_wdata;
        if (req_fire)
            let_rdata_reg <= let_mem[let_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg   <= 1'b1;
            clr_addr_reg     <= '0;
            hist_last_we_reg <= 1'b0;
            let_last_we_reg  <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s1_rd_reg        <= 1'b0;
            s1_hist_we_reg   <= 1'b0;
            s1_let_we_reg    <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + HIST_AW'(1);
                if (clr_addr_reg == HIST_AW'(tbs_pkg::BYTE_VALUES - 1))
                    clr_active_reg <= 1'b0;
            end
            hist_last_we_reg <= hist_we;
            let_last_we_reg  <= let_we;
            s1_valid_reg     <= req_fire;
            s1_rd_reg        <= req_fire && is_read;
            s1_hist_we_reg   <= req_fire && hist_we_s0;
            s1_let_we_reg    <= req_fire && let_we_s0;
        end
    end

    // Payload side of stage 1 and forwarding data: no reset needed
    always_ff @(posedge clk)
    begin
        hist_last_addr_reg <= s1_hist_addr_reg;
        let_last_addr_reg  <= s1_let_addr_reg;
        hist_last_data_reg <= hist_wdata;
        let_last_data_reg  <= let_wdata;
        if (req_fire)
        begin
            s1_hist_addr_reg <= hist_raddr;
            s1_let_addr_reg  <= let_raddr;
            s1_sel_reg       <= req.table_select;
            s1_err_reg       <= idx_err_s0;
            s1_words_reg     <= words_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: pick the requested counter and narrow or extend it to the result width
    // ------------------------------------------------------------------
    cnt_t sel_val;
    logic sel_err;
    logic [tbs_pkg::RESULT_WIDTH-1:0] sel_out;

    always_comb
    begin
        sel_val = '0;
        sel_err = 1'b0;
        unique case (tbs_pkg::table_sel_t'(s1_sel_reg))
            tbs_pkg::TBL_BYTE:  sel_val = hist_cur;
            tbs_pkg::TBL_LOWER,
            tbs_pkg::TBL_UPPER:
            begin
                sel_err = s1_err_reg;
                sel_val = s1_err_reg ? '0 : let_cur;
            end
            tbs_pkg::TBL_WORDS: sel_val = s1_words_reg;
            default: ;
        endcase
    end

    generate
        if (COUNT_WIDTH > tbs_pkg::RESULT_WIDTH) begin : g_sat
            // wide counters clip to the all-ones result
            assign sel_out = (|sel_val[COUNT_WIDTH-1:tbs_pkg::RESULT_WIDTH])
                           ? '1 : sel_val[tbs_pkg::RESULT_WIDTH-1:0];
        end
        else begin : g_ext
            assign sel_out = tbs_pkg::RESULT_WIDTH'(sel_val);
        end
    endgenerate

    // ------------------------------------------------------------------
    // Response buffer: three entries, so stage 1 never has to stall.
    // Admit a request only while the buffer plus the in-flight read fit.
    // ------------------------------------------------------------------
    tbs_pkg::rsp_t     rsp_buf_reg [RSP_DEPTH];
    logic [RSP_PW-1:0] rsp_wptr_reg, rsp_rptr_reg;
    logic [RSP_CW-1:0] rsp_cnt_reg, rsp_cnt_next;
    logic rsp_push, rsp_pop;

    assign rsp_push  = s1_valid_reg && s1_rd_reg;
    assign rsp_pop   = rsp_valid && rsp_ready;
    assign rsp_valid = (rsp_cnt_reg != '0);
    assign rsp       = rsp_buf_reg[rsp_rptr_reg];
    assign req_ready = !clr_active_reg
                    && ((rsp_cnt_reg + RSP_CW'(rsp_push)) < RSP_CW'(RSP_DEPTH));

    always_comb
    begin
        rsp_cnt_next = rsp_cnt_reg;
        if (rsp_push && !rsp_pop)
            rsp_cnt_next = rsp_cnt_reg + RSP_CW'(1);
        else if (!rsp_push && rsp_pop)
            rsp_cnt_next = rsp_cnt_reg - RSP_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_cnt_reg  <= '0;
            rsp_wptr_reg <= '0;
            rsp_rptr_reg <= '0;
        end
        else
        begin
            rsp_cnt_reg <= rsp_cnt_next;
            if (rsp_push)
                rsp_wptr_reg <= (rsp_wptr_reg == RSP_PW'(RSP_DEPTH - 1))
                              ? '0 : rsp_wptr_reg + RSP_PW'(1);
            if (rsp_pop)
                rsp_rptr_reg <= (rsp_rptr_reg == RSP_PW'(RSP_DEPTH - 1))
                              ? '0 : rsp_rptr_reg + RSP_PW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_push)
        begin
            rsp_buf_reg[rsp_wptr_reg].count_value <= sel_out;
            rsp_buf_reg[rsp_wptr_reg].index_error <= sel_err;
        end
    end

`ifndef ASSERT_OFF
    // A read in stage 1 always finds room in the response buffer
    a_rsp_room: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_rd_reg) |-> (rsp_cnt_reg < RSP_CW'(RSP_DEPTH)))
        else $error("response buffer overflow");

    // An accepted read becomes a stage 1 read in the next cycle
    a_read_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && is_read) |=> (s1_valid_reg && s1_rd_reg))
        else $error("accepted read lost before stage 1");

    // Counter memories are only incremented by data bytes
    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (hist_we || let_we) |-> !s1_rd_reg)
        else $error("counter write from a read request");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for text_byte_statistics_unit: a directed script, then text-like
// random traffic checked against an in-bench predictor of all counters.
// Depends on tbs_pkg and the unit itself; needs no files or arguments.
module tb_top;

    // Narrow counters so that saturation is reachable within a short run.
    localparam int         COUNT_W       = 8;
    localparam bit [63:0]  CNT_MAX       = {64{1'b1}} >> (64 - COUNT_W);
    // Extra wait after reads drain, so a data byte in flight finishes before config changes.
    localparam int         SETTLE_CYCLES = 4;
    localparam int         IDLE_LIMIT    = 3000;
    localparam int         PHASES        = 8;
    localparam int         PHASE_ITEMS   = 210;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          cfg_we    = 1'b0;
    logic  [1:0]   cfg_index = 2'd0;
    logic          cfg_wdata = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    tbs_pkg::req_t req       = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    tbs_pkg::rsp_t rsp;

    text_byte_statistics_unit #(
        .COUNT_WIDTH(COUNT_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: shadow copy of every counter and of the mode registers.
    // Counters are kept 64 bits wide and clipped at CNT_MAX.
    // ------------------------------------------------------------------
    bit [63:0] byte_tally  [tbs_pkg::BYTE_VALUES] = '{default: 64'd0};
    bit [63:0] lower_tally [tbs_pkg::LETTERS]     = '{default: 64'd0};
    bit [63:0] upper_tally [tbs_pkg::LETTERS]     = '{default: 64'd0};
    bit [63:0] word_tally  = 64'd0;
    bit        in_word     = 1'b0;

    // Mode registers at their reset values: histogram only.
    bit word_on   = 1'b0;
    bit letter_on = 1'b0;
    bit fold_on   = 1'b0;
    bit hist_on   = 1'b1;

    // Expected read responses, oldest first.
    tbs_pkg::rsp_t pending_counts [$];

    int errors      = 0;
    int n_bytes     = 0;
    int n_reads     = 0;
    int n_index_err = 0;
    int n_full      = 0;
    int n_configs   = 0;

    function automatic bit [63:0] bumped(bit [63:0] c);
        return (c < CNT_MAX) ? c + 64'd1 : c;
    endfunction

    // Fold one text byte into the shadow counters.
    function automatic void tally_byte(logic [7:0] b);
        bit sep;
        sep = (b == tbs_pkg::CH_SPACE) || (b == tbs_pkg::CH_NEWLINE);
        if (word_on)
        begin
            if (!sep && !in_word)
            begin
                word_tally = bumped(word_tally);
                in_word    = 1'b1;
            end
            else if (sep)
                in_word = 1'b0;
        end
        if (letter_on)
        begin
            if (b >= tbs_pkg::CH_LOWER_A && b <= tbs_pkg::CH_LOWER_Z)
                lower_tally[b - tbs_pkg::CH_LOWER_A] =
                    bumped(lower_tally[b - tbs_pkg::CH_LOWER_A]);
            if (b >= tbs_pkg::CH_UPPER_A && b <= tbs_pkg::CH_UPPER_Z)
            begin
                if (fold_on)
                    lower_tally[b - tbs_pkg::CH_UPPER_A] =
                        bumped(lower_tally[b - tbs_pkg::CH_UPPER_A]);
                else
                    upper_tally[b - tbs_pkg::CH_UPPER_A] =
                        bumped(upper_tally[b - tbs_pkg::CH_UPPER_A]);
            end
        end
        if (hist_on)
            byte_tally[b] = bumped(byte_tally[b]);
    endfunction

    // Work out the response to a read request from the shadow counters.
    function automatic tbs_pkg::rsp_t look_up_count(tbs_pkg::table_sel_t sel,
                                                    logic [7:0] idx);
        tbs_pkg::rsp_t r;
        bit [63:0]     v;
        v = 64'd0;
        r.index_error = 1'b0;
        case (sel)
            tbs_pkg::TBL_BYTE:  v = byte_tally[idx];
            tbs_pkg::TBL_LOWER,
            tbs_pkg::TBL_UPPER:
            begin
                if (idx < tbs_pkg::LETTERS)
                    v = (sel == tbs_pkg::TBL_LOWER) ? lower_tally[idx] : upper_tally[idx];
                else
                    r.index_error = 1'b1;
            end
            default:   v = word_tally;
        endcase
        r.count_value = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Present one request, hold it until accepted, then update the predictor.
    // A typed expectation, where given, replaces the predicted response.
    task automatic push_request(input tbs_pkg::req_t r, input bit typed,
                                input tbs_pkg::rsp_t want);
        tbs_pkg::rsp_t predicted;
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        if (r.req_type == tbs_pkg::REQ_DATA)
        begin
            tally_byte(r.data_byte);
            n_bytes++;
        end
        else
        begin
            predicted = look_up_count(tbs_pkg::table_sel_t'(r.table_select),
                                      r.entry_index);
            pending_counts.push_back(typed ? want : predicted);
            n_reads++;
        end
    endtask

    // Drop valid and wait on clock edges until every read has been answered.
    task automatic drain_reads();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_counts.size() != 0);
    endtask

    // Drain, then let a data byte still in flight finish its update.
    task automatic settle();
        drain_reads();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the unit must be idle. Deassert on the next edge so that
    // back-to-back writes never raise and lower the enable in the same step.
    task automatic write_reg(input logic [1:0] idx, input logic val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            tbs_pkg::CFG_WORD_EN:   word_on   = val;
            tbs_pkg::CFG_LETTER_EN: letter_on = val;
            tbs_pkg::CFG_FOLD_CASE: fold_on   = val;
            default:                hist_on   = val;
        endcase
        n_configs++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Directed script
    // ------------------------------------------------------------------
    typedef struct {
        bit            is_cfg;
        logic [1:0]    reg_idx;
        logic          reg_val;
        tbs_pkg::req_t r;
        bit            typed;
        tbs_pkg::rsp_t want;
    } script_row_t;

    script_row_t script [$];

    function automatic void add_cfg(logic [1:0] idx, logic val);
        script_row_t s;
        s         = '{default: '0};
        s.is_cfg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        script.push_back(s);
    endfunction

    function automatic void add_data(logic [7:0] b);
        script_row_t s;
        s                = '{default: '0};
        s.r.req_type     = tbs_pkg::REQ_DATA;
        s.r.data_byte    = b;
        s.r.table_select = ~b[1:0];
        s.r.entry_index  = ~b;
        script.push_back(s);
    endfunction

    function automatic void add_read(tbs_pkg::table_sel_t sel, logic [7:0] idx);
        script_row_t s;
        s                = '{default: '0};
        s.r.req_type     = tbs_pkg::REQ_READ;
        s.r.data_byte    = ~idx;
        s.r.table_select = sel;
        s.r.entry_index  = idx;
        script.push_back(s);
    endfunction

    function automatic void add_read_typed(tbs_pkg::table_sel_t sel, logic [7:0] idx,
                                           logic [31:0] cnt, logic err);
        add_read(sel, idx);
        script[$].typed             = 1'b1;
        script[$].want.count_value  = cnt;
        script[$].want.index_error  = err;
    endfunction

    // ------------------------------------------------------------------
    // Random text generator
    // ------------------------------------------------------------------
    logic [7:0] hot_byte;

    // Mostly letters and separators, a frequent hot letter to drive counters into
    // saturation, some arbitrary bytes as noise, and reads of every table.
    function automatic tbs_pkg::req_t next_text_request(int sep_pct);
        tbs_pkg::req_t r;
        int            roll;
        r.req_type     = tbs_pkg::REQ_DATA;
        r.data_byte    = 8'($urandom);
        r.table_select = 2'($urandom);
        r.entry_index  = 8'($urandom);
        roll           = $urandom_range(0, 99);
        if (roll < 20)
        begin
            r.req_type = tbs_pkg::REQ_READ;
            case (tbs_pkg::table_sel_t'(r.table_select))
                tbs_pkg::TBL_BYTE:
                    if ($urandom_range(0, 1) == 0)
                        r.entry_index = hot_byte;
                tbs_pkg::TBL_LOWER,
                tbs_pkg::TBL_UPPER:
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 30)
                        r.entry_index = (hot_byte >= tbs_pkg::CH_LOWER_A)
                                      ? hot_byte - tbs_pkg::CH_LOWER_A
                                      : hot_byte - tbs_pkg::CH_UPPER_A;
                    else if (roll < 85)
                        r.entry_index = 8'($urandom_range(0, tbs_pkg::LETTERS - 1));
                    else
                        r.entry_index = 8'($urandom_range(tbs_pkg::LETTERS, 255));
                end
                default: ;
            endcase
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < sep_pct)
                r.data_byte = ($urandom_range(0, 1) == 0) ? tbs_pkg::CH_SPACE
                                                          : tbs_pkg::CH_NEWLINE;
            else if (roll < sep_pct + 25)
                r.data_byte = hot_byte;
            else if (roll < sep_pct + 33)
                r.data_byte = 8'($urandom);
            else if ($urandom_range(0, 9) < 6)
                r.data_byte = tbs_pkg::CH_LOWER_A
                            + 8'($urandom_range(0, tbs_pkg::LETTERS - 1));
            else
                r.data_byte = tbs_pkg::CH_UPPER_A
                            + 8'($urandom_range(0, tbs_pkg::LETTERS - 1));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        tbs_pkg::rsp_t none;
        tbs_pkg::req_t r;
        bit            mode [4];
        logic [1:0]    reg_order [4];
        int            burst_left;
        int            sep_pct;

        none      = '0;
        reg_order = '{tbs_pkg::CFG_WORD_EN, tbs_pkg::CFG_LETTER_EN,
                      tbs_pkg::CFG_FOLD_CASE, tbs_pkg::CFG_HIST_EN};

        // Reset values first: every counter reads zero, bad letter indexes flag.
        add_read_typed(tbs_pkg::TBL_WORDS, 8'hFF, 32'd0, 1'b0);
        add_read_typed(tbs_pkg::TBL_BYTE,  8'hFF, 32'd0, 1'b0);
        add_read_typed(tbs_pkg::TBL_LOWER, 8'd25, 32'd0, 1'b0);
        add_read_typed(tbs_pkg::TBL_UPPER, 8'd26, 32'd0, 1'b1);
        add_read_typed(tbs_pkg::TBL_LOWER, 8'hFF, 32'd0, 1'b1);
        // Words and letters on: a high byte opens a word at stream start,
        // separators close words, NUL starts one.
        add_cfg(tbs_pkg::CFG_WORD_EN, 1'b1);
        add_cfg(tbs_pkg::CFG_LETTER_EN, 1'b1);
        add_data(8'hFF);
        add_data(tbs_pkg::CH_SPACE);
        add_data(tbs_pkg::CH_UPPER_A);
        add_data(tbs_pkg::CH_LOWER_Z);
        add_data(tbs_pkg::CH_NEWLINE);
        add_data(8'h00);
        add_data(tbs_pkg::CH_UPPER_Z);
        add_read(tbs_pkg::TBL_WORDS, 8'h00);
        add_read(tbs_pkg::TBL_BYTE,  8'hFF);
        add_read(tbs_pkg::TBL_UPPER, 8'd0);
        add_read(tbs_pkg::TBL_UPPER, 8'd25);
        add_read(tbs_pkg::TBL_LOWER, 8'd25);
        // Fold uppercase into the lowercase table.
        add_cfg(tbs_pkg::CFG_FOLD_CASE, 1'b1);
        add_data(tbs_pkg::CH_UPPER_Z);
        add_read(tbs_pkg::TBL_LOWER, 8'd25);
        add_read(tbs_pkg::TBL_UPPER, 8'd25);
        // Disabled statistics keep their counts but still answer reads.
        add_cfg(tbs_pkg::CFG_HIST_EN, 1'b0);
        add_cfg(tbs_pkg::CFG_WORD_EN, 1'b0);
        add_data(tbs_pkg::CH_SPACE);
        add_data(tbs_pkg::CH_LOWER_A);
        add_read(tbs_pkg::TBL_BYTE,  tbs_pkg::CH_SPACE);
        add_read(tbs_pkg::TBL_WORDS, 8'h00);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                settle();
                write_reg(script[i].reg_idx, script[i].reg_val);
            end
            else
                push_request(script[i].r, script[i].typed, script[i].want);
        end

        // Random phases, each under its own mode setting.
        hot_byte = ($urandom_range(0, 1) == 0)
                 ? tbs_pkg::CH_LOWER_A + 8'($urandom_range(0, 25))
                 : tbs_pkg::CH_UPPER_A + 8'($urandom_range(0, 25));
        burst_left = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       mode = '{1'b1, 1'b1, 1'b0, 1'b1};
                1:       mode = '{1'b0, 1'b0, 1'b0, 1'b0};
                2:       mode = '{1'b1, 1'b1, 1'b1, 1'b1};
                default: foreach (mode[k]) mode[k] = $urandom_range(0, 1);
            endcase
            settle();
            foreach (reg_order[k])
                write_reg(reg_order[k], mode[k]);
            sep_pct = $urandom_range(5, 50);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Hold off once per phase until the response queue is empty.
                if (n == PHASE_ITEMS / 2)
                    drain_reads();
                if (burst_left == 0)
                begin
                    req_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                              : $urandom_range(1, 24);
                end
                r = next_text_request(sep_pct);
                push_request(r, 1'b0, none);
                burst_left--;
            end
        end

        drain_reads();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);

        $display("Covered %0d data bytes and %0d reads over %0d register writes,",
                 n_bytes, n_reads, n_configs);
        $display("with %0d bad letter indexes and %0d reads of full counters.",
                 n_index_err, n_full);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Response side: stall pattern and checker
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int mode_left  = 0;
    int hold_left  = 0;

    // Switch among always ready, coin flips, sparse ready and long stalls.
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 120);
        end
        mode_left--;
        case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (hold_left == 0)
                    hold_left = $urandom_range(2, 16);
                hold_left--;
                rsp_ready <= (hold_left == 0);
            end
        endcase
    end

    // Compare each accepted response with the oldest expectation.
    always @(posedge clk)
    begin
        tbs_pkg::rsp_t exp_rsp;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_counts.size() == 0)
            begin
                $error("response with no read request pending: count_value %0d",
                       rsp.count_value);
                errors++;
            end
            else
            begin
                exp_rsp = pending_counts.pop_front();
                if (rsp.count_value !== exp_rsp.count_value)
                begin
                    $error("count_value: expected %0d, got %0d",
                           exp_rsp.count_value, rsp.count_value);
                    errors++;
                end
                if (rsp.index_error !== exp_rsp.index_error)
                begin
                    $error("index_error: expected %0b, got %0b",
                           exp_rsp.index_error, rsp.index_error);
                    errors++;
                end
                if (exp_rsp.index_error)
                    n_index_err++;
                if (exp_rsp.count_value == CNT_MAX[31:0])
                    n_full++;
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no request or response moved in %0d cycles, %0d pending",
                         IDLE_LIMIT, pending_counts.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

endmodule
